// File: rtl/core/swmf_pkg.sv
// swmf_pkg: shared constants, types and register codes of the sorted window mean filter
// no dependencies; used by every file under rtl/core

package swmf_pkg;

    // burst store depth and sorting chain length
    localparam int MAX_SAMPLES = 128;

    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = $clog2(MAX_SAMPLES);
    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int FRAC_W   = 8;
    localparam int SUM_W    = SAMPLE_W + IDX_W;
    localparam int DIV_W    = SUM_W + FRAC_W;
    localparam int MEAN_W   = 24;
    localparam int USED_W   = 8;

    // register field widths
    localparam int MODE_W   = 1;
    localparam int SCOUNT_W = 8;
    localparam int WIN_W    = 16;
    localparam int RANK_W   = 7;
    localparam int MCOUNT_W = 8;
    localparam int WIDE_W   = (CNT_W > SCOUNT_W) ? CNT_W : SCOUNT_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_RANK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_COUNT     = 3'd4;

    // register reset values
    localparam logic [MODE_W-1:0]   RST_FILTER_MODE    = 1'b1;
    localparam logic [SCOUNT_W-1:0] RST_SAMPLE_COUNT   = 8'd100;
    localparam logic [WIN_W-1:0]    RST_WINDOW_WIDTH   = 16'd30;
    localparam logic [RANK_W-1:0]   RST_REFERENCE_RANK = 7'd50;
    localparam logic [MCOUNT_W-1:0] RST_MEAN_COUNT     = 8'd100;

    localparam logic [MODE_W-1:0] MODE_DROP_MAX = 1'b0;

    // control of the sorting chain
    typedef struct packed {
        logic clear;
        logic insert;
        logic rotate;
    } t_chain_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOAD,
        ST_FIND,
        ST_SUM,
        ST_DIV,
        ST_WAIT
    } t_state;

endpackage

// File: rtl/core/sorted_window_mean_filter.sv
// sorted_window_mean_filter: top level with register file, burst store, sequencer and accumulator
// depends on swmf_pkg, swmf_chain, swmf_div

// Samples are taken one per cycle while busy is low (start high). The last sample of a
// burst raises busy while the burst store is read into the sorting chain, the sorted
// chain is rotated past the accumulator (twice in window mode so the reference value is
// known first) and the mean is divided out one bit a cycle. The result shows for one
// cycle with o_result_valid, in the same cycle busy falls; the receiver cannot stall it,
// so it must take it then. Register writes are taken at any time and never restart a
// burst.

module sorted_window_mean_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [swmf_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                            i_cfg_we,
    input  logic [swmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [swmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_result_valid,
    output logic [swmf_pkg::MEAN_W-1:0]     o_mean_value,
    output logic [swmf_pkg::USED_W-1:0]     o_used_count
);

    localparam int N  = swmf_pkg::MAX_SAMPLES;
    localparam int WW = swmf_pkg::WIDE_W;
    localparam int CW = swmf_pkg::CNT_W;
    localparam int SW = swmf_pkg::SAMPLE_W;

    // configuration registers
    logic [swmf_pkg::MODE_W-1:0]   r_filter_mode;
    logic [swmf_pkg::SCOUNT_W-1:0] r_sample_count;
    logic [swmf_pkg::WIN_W-1:0]    r_window_width;
    logic [swmf_pkg::RANK_W-1:0]   r_reference_rank;
    logic [swmf_pkg::MCOUNT_W-1:0] r_mean_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode    <= swmf_pkg::RST_FILTER_MODE;
            r_sample_count   <= swmf_pkg::RST_SAMPLE_COUNT;
            r_window_width   <= swmf_pkg::RST_WINDOW_WIDTH;
            r_reference_rank <= swmf_pkg::RST_REFERENCE_RANK;
            r_mean_count     <= swmf_pkg::RST_MEAN_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                swmf_pkg::CFG_FILTER_MODE:    r_filter_mode    <= i_cfg_data[0];
                swmf_pkg::CFG_SAMPLE_COUNT:   r_sample_count   <= i_cfg_data[7:0];
                swmf_pkg::CFG_WINDOW_WIDTH:   r_window_width   <= i_cfg_data;
                swmf_pkg::CFG_REFERENCE_RANK: r_reference_rank <= i_cfg_data[6:0];
                swmf_pkg::CFG_MEAN_COUNT:     r_mean_count     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // derived burst length, reference rank and mode 0 end rank
    logic [WW-1:0] w_sc;
    logic [WW-1:0] w_n;
    logic [WW-1:0] w_rank;
    logic [WW-1:0] w_ref;
    logic [WW-1:0] w_mc;
    logic [WW-1:0] w_hi;

    assign w_sc   = WW'(r_sample_count);
    assign w_n    = (w_sc == '0) ? WW'(1) : ((w_sc > WW'(N)) ? WW'(N) : w_sc);
    assign w_rank = WW'(r_reference_rank);
    assign w_ref  = (w_rank < w_n) ? w_rank : (w_n - WW'(1));
    assign w_mc   = WW'(r_mean_count);
    assign w_hi   = (w_mc < w_n) ? w_mc : w_n;

    // state
    swmf_pkg::t_state r_state;
    swmf_pkg::t_state n_state;

    logic [WW-1:0]           r_loaded;
    logic [CW-1:0]           r_idx;
    logic [SW-1:0]           r_mem [N];
    logic [SW-1:0]           r_rd_data;
    logic [SW-1:0]           r_center;
    logic [swmf_pkg::SUM_W-1:0] r_sum;
    logic [CW-1:0]           r_cnt;
    logic                    r_out_valid;
    logic [swmf_pkg::MEAN_W-1:0] r_mean;
    logic [swmf_pkg::USED_W-1:0] r_used;

    logic                    w_accept;
    logic [WW-1:0]           w_loaded_inc;
    logic                    w_burst_done;
    logic [WW-1:0]           w_idx_wide;
    logic                    w_last_load;
    logic                    w_last_rot;
    logic [swmf_pkg::IDX_W-1:0] w_rd_addr;
    swmf_pkg::t_chain_ctrl   w_ctrl;
    logic                    w_div_start;

    logic [SW-1:0]           w_head;
    logic                    w_div_done;
    logic [swmf_pkg::DIV_W-1:0] w_quot;

    assign w_accept     = start && (r_state == swmf_pkg::ST_IDLE);
    assign w_loaded_inc = r_loaded + WW'(1);
    assign w_burst_done = w_loaded_inc >= w_n;
    assign w_idx_wide   = WW'(r_idx);
    assign w_last_load  = (w_idx_wide + WW'(1)) == w_n;
    assign w_last_rot   = r_idx == CW'(N - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swmf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_ctrl      = '0;
        w_rd_addr   = '0;
        w_div_start = 1'b0;
        case (r_state)
            swmf_pkg::ST_IDLE: begin
                if (w_accept && w_burst_done) begin
                    n_state = swmf_pkg::ST_CLEAR;
                end
            end
            swmf_pkg::ST_CLEAR: begin
                w_ctrl.clear = 1'b1;
                n_state      = swmf_pkg::ST_LOAD;
            end
            swmf_pkg::ST_LOAD: begin
                w_ctrl.insert = 1'b1;
                w_rd_addr     = swmf_pkg::IDX_W'(r_idx + CW'(1));
                if (w_last_load) begin
                    n_state = (r_filter_mode == swmf_pkg::MODE_DROP_MAX) ?
                              swmf_pkg::ST_SUM : swmf_pkg::ST_FIND;
                end
            end
            swmf_pkg::ST_FIND: begin
                w_ctrl.rotate = 1'b1;
                if (w_last_rot) begin
                    n_state = swmf_pkg::ST_SUM;
                end
            end
            swmf_pkg::ST_SUM: begin
                w_ctrl.rotate = 1'b1;
                if (w_last_rot) begin
                    n_state = swmf_pkg::ST_DIV;
                end
            end
            swmf_pkg::ST_DIV: begin
                w_div_start = 1'b1;
                n_state     = swmf_pkg::ST_WAIT;
            end
            swmf_pkg::ST_WAIT: begin
                if (w_div_done) begin
                    n_state = swmf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swmf_pkg::ST_IDLE;
            end
        endcase
    end

    // burst store
    always_ff @(posedge i_clk) begin
        if (w_accept && (r_loaded < WW'(N))) begin
            r_mem[r_loaded[swmf_pkg::IDX_W-1:0]] <= i_sample;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
        end else if (w_accept) begin
            r_loaded <= w_burst_done ? '0 : w_loaded_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            case (r_state)
                swmf_pkg::ST_CLEAR: r_idx <= '0;
                swmf_pkg::ST_LOAD:  r_idx <= w_last_load ? '0 : r_idx + CW'(1);
                swmf_pkg::ST_FIND,
                swmf_pkg::ST_SUM:   r_idx <= w_last_rot ? '0 : r_idx + CW'(1);
                default:            r_idx <= '0;
            endcase
        end
    end

    swmf_chain u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_new        (r_rd_data),
        .o_head_value (w_head)
    );

    // selection of the sorted entry now at the head
    logic [SW:0] w_delta;
    logic [SW-1:0] w_dist;
    logic        w_take;

    assign w_delta = {1'b0, w_head} - {1'b0, r_center};
    assign w_dist  = w_delta[SW] ? SW'(-w_delta) : w_delta[SW-1:0];

    always_comb begin
        if (r_filter_mode == swmf_pkg::MODE_DROP_MAX) begin
            if (w_hi < WW'(2)) begin
                w_take = w_idx_wide == '0;
            end else begin
                w_take = (w_idx_wide != '0) && (w_idx_wide < w_hi);
            end
        end else begin
            w_take = (w_idx_wide < w_n) && (w_dist <= r_window_width);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == swmf_pkg::ST_FIND && w_idx_wide == w_ref) begin
            r_center <= w_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == swmf_pkg::ST_CLEAR) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (r_state == swmf_pkg::ST_SUM && w_take) begin
            r_sum <= r_sum + swmf_pkg::SUM_W'(w_head);
            r_cnt <= r_cnt + CW'(1);
        end
    end

    swmf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({r_sum, swmf_pkg::FRAC_W'(0)}),
        .i_divisor  (r_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_state == swmf_pkg::ST_WAIT) && w_div_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == swmf_pkg::ST_WAIT && w_div_done) begin
            r_mean <= w_quot[swmf_pkg::MEAN_W-1:0];
            r_used <= swmf_pkg::USED_W'(r_cnt);
        end
    end

    assign busy           = r_state != swmf_pkg::ST_IDLE;
    assign o_result_valid = r_out_valid;
    assign o_mean_value   = r_mean;
    assign o_used_count   = r_used;

endmodule

// File: rtl/core/swmf_cell.sv
// swmf_cell: one cell of the descending insertion sorting chain
// depends on swmf_pkg

module swmf_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swmf_pkg::t_chain_ctrl         i_ctrl,
    input  logic [swmf_pkg::SAMPLE_W-1:0] i_new,
    input  logic [swmf_pkg::SAMPLE_W-1:0] i_left_value,
    input  logic                          i_left_valid,
    input  logic                          i_left_gt,
    input  logic [swmf_pkg::SAMPLE_W-1:0] i_right_value,
    input  logic                          i_right_valid,
    output logic [swmf_pkg::SAMPLE_W-1:0] o_value,
    output logic                          o_valid,
    output logic                          o_gt
);

    logic [swmf_pkg::SAMPLE_W-1:0] r_value;
    logic                          r_valid;

    // new value belongs above this cell (empty cells rank lowest)
    assign o_gt    = !r_valid || (i_new > r_value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.insert) begin
            if (i_left_gt) begin
                r_valid <= i_left_valid;
            end else if (o_gt) begin
                r_valid <= 1'b1;
            end
        end else if (i_ctrl.rotate) begin
            r_valid <= i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            if (i_left_gt) begin
                r_value <= i_left_value;
            end else if (o_gt) begin
                r_value <= i_new;
            end
        end else if (i_ctrl.rotate) begin
            r_value <= i_right_value;
        end
    end

endmodule

// File: rtl/core/swmf_chain.sv
// swmf_chain: row of sorting cells, insertion from the left, rotation toward cell 0
// depends on swmf_pkg and swmf_cell

module swmf_chain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swmf_pkg::t_chain_ctrl         i_ctrl,
    input  logic [swmf_pkg::SAMPLE_W-1:0] i_new,
    output logic [swmf_pkg::SAMPLE_W-1:0] o_head_value
);

    localparam int N = swmf_pkg::MAX_SAMPLES;

    logic [swmf_pkg::SAMPLE_W-1:0] w_value [N];
    logic                          w_valid [N];
    logic                          w_gt    [N];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic [swmf_pkg::SAMPLE_W-1:0] w_lv;
            logic                          w_lvalid;
            logic                          w_lgt;
            if (g == 0) begin : g_first
                assign w_lv     = '0;
                assign w_lvalid = 1'b0;
                assign w_lgt    = 1'b0;
            end else begin : g_rest
                assign w_lv     = w_value[g-1];
                assign w_lvalid = w_valid[g-1];
                assign w_lgt    = w_gt[g-1];
            end

            swmf_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (i_ctrl),
                .i_new         (i_new),
                .i_left_value  (w_lv),
                .i_left_valid  (w_lvalid),
                .i_left_gt     (w_lgt),
                .i_right_value (w_value[(g + 1) % N]),
                .i_right_valid (w_valid[(g + 1) % N]),
                .o_value       (w_value[g]),
                .o_valid       (w_valid[g]),
                .o_gt          (w_gt[g])
            );
        end
    endgenerate

    assign o_head_value = w_value[0];

endmodule

// File: rtl/core/swmf_div.sv
// swmf_div: restoring divider, one quotient bit per cycle
// depends on swmf_pkg

module swmf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [swmf_pkg::DIV_W-1:0] i_dividend,
    input  logic [swmf_pkg::CNT_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [swmf_pkg::DIV_W-1:0] o_quotient
);

    localparam int DW    = swmf_pkg::DIV_W;
    localparam int CW    = swmf_pkg::CNT_W;
    localparam int STEPW = $clog2(DW);

    logic [DW-1:0]    r_q;
    logic [CW-1:0]    r_rem;
    logic [CW-1:0]    r_div;
    logic [STEPW-1:0] r_step;
    logic             r_busy;
    logic             r_done;

    logic [CW:0] w_trial;
    logic        w_ge;
    logic [CW:0] w_diff;

    assign w_trial = {r_rem, r_q[DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEPW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];
            r_q   <= {r_q[DW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// File: rtl/core/swmf_checker.sv
// swmf_checker: port-level assertions on the sorted window mean filter, bound to the top level
// depends on swmf_pkg and sorted_window_mean_filter

module swmf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            busy,
    input logic                            o_result_valid,
    input logic [swmf_pkg::USED_W-1:0]     o_used_count
);

    // reset leaves no result and no work in flight
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid && !busy)
        else $error("result or busy right after reset");

    // a result ends a busy phase
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a preceding busy phase");

    // the result strobe is never raised twice in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // the average always holds at least one and at most a full store of samples
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_used_count != '0) &&
                           (o_used_count <= swmf_pkg::USED_W'(swmf_pkg::MAX_SAMPLES)))
        else $error("used count out of range");

endmodule

bind sorted_window_mean_filter swmf_checker u_swmf_checker (.*);
